[hdl/hsl_to_rgb_converter_top_assert.svh]
// Assertion macros for the HSL to RGB converter.
`ifndef HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define H2R_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define H2R_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/h2r_pkg.sv]
// Constants and types shared by the HSL to RGB converter.
`timescale 1ns / 1ps
package h2r_pkg;

  localparam int unsigned HueW  = 16;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChanW = 8;

  // floor(2^24 / 360): quotient estimate is low by at most one
  localparam logic [15:0] HueRecip = 16'd46603;
  localparam logic [8:0]  HueMod   = 9'd360;

  localparam logic [PctW-1:0] PctMax = 7'd100;

  // common denominator of c, x and m
  localparam logic [27:0] Den      = 28'd600000;
  localparam logic [27:0] HalfDen  = 28'd300000;
  // floor(2^38 / 600000): channel estimate is low by at most one
  localparam logic [18:0] ChanRecip = 19'd458129;

  typedef logic [19:0] frac_t;
  typedef logic [27:0] scaled_t;
  typedef logic [13:0] chroma_t;

  typedef enum logic [2:0] {
    SecRY = 3'd0,
    SecYG = 3'd1,
    SecGC = 3'd2,
    SecCB = 3'd3,
    SecBM = 3'd4,
    SecMR = 3'd5
  } sector_e;

endpackage

[hdl/hsl_to_rgb_converter_top.sv]
// HSL to RGB converter: six-stage pipeline, one color per clock.
// The valid strobe rises at the same edge that loads the result registers.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Reset clears only the valid bits of the pipeline; no results follow reset.
// Critical path: the 28x19 reciprocal multiply of the channel divide stage.
`timescale 1ns / 1ps
module hsl_to_rgb_converter_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [h2r_pkg::HueW-1:0]  hue_degrees_i,
  input  logic [h2r_pkg::PctW-1:0]  saturation_pct_i,
  input  logic [h2r_pkg::PctW-1:0]  lightness_pct_i,
  output logic                      valid_o,
  output logic [h2r_pkg::ChanW-1:0] red_o,
  output logic [h2r_pkg::ChanW-1:0] green_o,
  output logic [h2r_pkg::ChanW-1:0] blue_o
);
  import h2r_pkg::*;

  logic [5:0] v_q;

  // stage 1: hue quotient estimate, clamp, chroma
  logic [PctW-1:0] sat_cl, lig_cl;
  logic [7:0]      lig2;
  logic [7:0]      dl;
  logic [31:0]     hprod;
  chroma_t         cc1_d, cc1_q;
  logic [HueW-1:0] hue1_q;
  logic [7:0]      hq1_q;
  logic [PctW-1:0] lig1_q;

  // stage 2: hue remainder, sector, weights, c and m
  logic [15:0]     qx360;
  logic [15:0]     rem16;
  logic [9:0]      rem10;
  logic [8:0]      hr;
  logic [6:0]      hm;
  logic [5:0]      dh;
  sector_e         sec2_d, sec2_q;
  logic [5:0]      w2_q;
  chroma_t         cc2_q;
  frac_t           c2_d, c2_q, m2_d, m2_q;
  frac_t           l6k, cc30;

  // stage 3: secondary component
  frac_t           x3_d;
  sector_e         sec3_q;
  frac_t           c3_q, x3_q, m3_q;

  // stage 4: per-channel numerator
  frac_t           comp [3];
  frac_t           num  [3];
  scaled_t         p4_d [3];
  scaled_t         p4_q [3];

  // stage 5: reciprocal multiply
  logic [46:0]     cprod [3];
  logic [7:0]      est5_q [3];
  scaled_t         p5_q [3];

  // stage 6: correction
  scaled_t         estx [3];
  scaled_t         rem6 [3];
  logic [ChanW-1:0] chan6 [3];
  logic [ChanW-1:0] red_q, green_q, blue_q;

  assign busy = 1'b0;

  always_comb begin
    sat_cl = (saturation_pct_i > PctMax) ? PctMax : saturation_pct_i;
    lig_cl = (lightness_pct_i > PctMax) ? PctMax : lightness_pct_i;
    lig2   = {lig_cl, 1'b0};
    dl     = (lig2 >= 8'd100) ? (lig2 - 8'd100) : (8'd100 - lig2);
    cc1_d  = {7'd0, (PctMax - dl[6:0])} * {7'd0, sat_cl};
    hprod  = {16'd0, hue_degrees_i} * {16'd0, HueRecip};
  end

  always_comb begin
    qx360 = {8'd0, hq1_q} * 16'd360;
    rem16 = hue1_q - qx360;
    rem10 = rem16[9:0];
    hr    = (rem10 >= {1'b0, HueMod}) ? 9'(rem10 - {1'b0, HueMod}) : rem10[8:0];
    priority if (hr < 9'd60) begin
      sec2_d = SecRY;
      hm     = hr[6:0];
    end else if (hr < 9'd120) begin
      sec2_d = SecYG;
      hm     = hr[6:0];
    end else if (hr < 9'd180) begin
      sec2_d = SecGC;
      hm     = 7'(hr - 9'd120);
    end else if (hr < 9'd240) begin
      sec2_d = SecCB;
      hm     = 7'(hr - 9'd120);
    end else if (hr < 9'd300) begin
      sec2_d = SecBM;
      hm     = 7'(hr - 9'd240);
    end else begin
      sec2_d = SecMR;
      hm     = 7'(hr - 9'd240);
    end
    dh   = (hm >= 7'd60) ? 6'(hm - 7'd60) : 6'(7'd60 - hm);
    c2_d = {6'd0, cc1_q} * 20'd60;
    l6k  = {13'd0, lig1_q} * 20'd6000;
    cc30 = {6'd0, cc1_q} * 20'd30;
    m2_d = l6k - cc30;
  end

  assign x3_d = {6'd0, cc2_q} * {14'd0, 6'd60 - w2_q};

  always_comb begin
    unique case (sec3_q)
      SecRY: begin
        comp[0] = c3_q; comp[1] = x3_q; comp[2] = '0;
      end
      SecYG: begin
        comp[0] = x3_q; comp[1] = c3_q; comp[2] = '0;
      end
      SecGC: begin
        comp[0] = '0; comp[1] = c3_q; comp[2] = x3_q;
      end
      SecCB: begin
        comp[0] = '0; comp[1] = x3_q; comp[2] = c3_q;
      end
      SecBM: begin
        comp[0] = x3_q; comp[1] = '0; comp[2] = c3_q;
      end
      SecMR: begin
        comp[0] = c3_q; comp[1] = '0; comp[2] = x3_q;
      end
      default: begin
        comp[0] = '0; comp[1] = '0; comp[2] = '0;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      num[i]  = comp[i] + m3_q;
      p4_d[i] = {num[i], 8'd0} - {8'd0, num[i]} + HalfDen;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cprod[i] = {19'd0, p4_q[i]} * {28'd0, ChanRecip};
      estx[i]  = {20'd0, est5_q[i]} * Den;
      rem6[i]  = p5_q[i] - estx[i];
      chan6[i] = (rem6[i] >= Den) ? (est5_q[i] + 8'd1) : est5_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    hue1_q <= hue_degrees_i;
    hq1_q  <= hprod[31:24];
    cc1_q  <= cc1_d;
    lig1_q <= lig_cl;

    sec2_q <= sec2_d;
    w2_q   <= dh;
    cc2_q  <= cc1_q;
    c2_q   <= c2_d;
    m2_q   <= m2_d;

    sec3_q <= sec2_q;
    c3_q   <= c2_q;
    x3_q   <= x3_d;
    m3_q   <= m2_q;

    for (int i = 0; i < 3; i++) begin
      p4_q[i]   <= p4_d[i];
      p5_q[i]   <= p4_q[i];
      est5_q[i] <= cprod[i][45:38];
    end

    red_q   <= chan6[0];
    green_q <= chan6[1];
    blue_q  <= chan6[2];
  end

  assign valid_o = v_q[5];
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

`include "hsl_to_rgb_converter_top_assert.svh"

  `H2R_ASSERT_IMP(a_hue_reduced, v_q[0], hr < HueMod, "hue remainder not below 360")
  `H2R_ASSERT_IMP(a_offset_nonneg, v_q[0], l6k >= cc30, "lightness offset went negative")
  `H2R_ASSERT_IMP(a_num_bound, v_q[2], (num[0] <= Den[19:0]) && (num[1] <= Den[19:0]) && (num[2] <= Den[19:0]), "channel numerator above denominator")
  `H2R_ASSERT_IMP(a_est_close, v_q[4], (rem6[0] < {Den[26:0], 1'b0}) && (rem6[1] < {Den[26:0], 1'b0}) && (rem6[2] < {Den[26:0], 1'b0}), "channel estimate off by more than one")
  `H2R_ASSERT_NXT(a_rounding, v_q[2], (p4_q[0] >= HalfDen) && (p4_q[1] >= HalfDen) && (p4_q[2] >= HalfDen), "rounding offset missing")

endmodule
